// ===== hw/rtl/incremental_mst_two_cost_minimizer_defines.svh =====
// Assertion macros shared by the checker of the spanning-tree cost minimizer
`ifndef INCREMENTAL_MST_TWO_COST_MINIMIZER_DEFINES_SVH
`define INCREMENTAL_MST_TWO_COST_MINIMIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IMSTCM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, disabled during reset
`define IMSTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hw/rtl/imstcm_pkg.sv =====
// Types and constants of the spanning-tree cost minimizer
`default_nettype none
package imstcm_pkg;

	localparam int NODE_W   = 9;
	localparam int COST_W   = 30;
	localparam int BEST_W   = 61;
	localparam int KEPT_W   = 8;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
	localparam logic [1:0] REG_GOLD_PRICE   = 2'd1;
	localparam logic [1:0] REG_SILVER_PRICE = 2'd2;

	typedef struct packed {
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [COST_W-1:0] silver;
	} kept_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_RD,
		ST_LD,
		ST_WA,
		ST_WB,
		ST_NEXT,
		ST_COST,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/imstcm_cost.sv =====
// Candidate cost pipeline: gold*gold_price + silver*silver_price over three stages
`default_nettype none
module imstcm_cost
	import imstcm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [COST_W-1:0] gold,
	input  wire logic [COST_W-1:0] silver_max,
	input  wire logic [COST_W-1:0] gold_price,
	input  wire logic [COST_W-1:0] silver_price,
	output logic                   cand_valid,
	output logic [BEST_W-1:0]      cand
);

	logic                  vld_s1, vld_s2, vld_s3;
	logic [2*COST_W-1:0]   pg_s1, pg_s2, ps_s2;
	logic [COST_W-1:0]     smax_s1;
	logic [BEST_W-1:0]     cand_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pg_s1   <= (2*COST_W)'(gold) * (2*COST_W)'(gold_price);
		smax_s1 <= silver_max;
		pg_s2   <= pg_s1;
		ps_s2   <= (2*COST_W)'(smax_s1) * (2*COST_W)'(silver_price);
		cand_s3 <= BEST_W'(pg_s2) + BEST_W'(ps_s2);
	end

	assign cand_valid = vld_s3;
	assign cand       = cand_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/incremental_mst_two_cost_minimizer.sv =====
// Incremental two-cost spanning-tree minimizer: one edge in, one running-minimum result out.
// Each accepted edge with both endpoints in 1..n is merged, in silver order, into the kept
// forest list and Kruskal is re-run over that list on a fresh union-find; an edge with a bad
// endpoint goes straight to the result and leaves the state alone. A good edge first sweeps
// the root-link memory to initialize it, then scans the list, and runs the cost pipeline
// only when the forest spans; root lookups walk parent links in the root-link memory, one
// link per cycle on its single read port, and a kept entry with an endpoint above the node
// count is skipped. The kept list lives in a ping-pong memory, read from one half and
// compacted into the other. An item with last_edge set reports its result and then clears
// the kept list and the best cost; the registers keep their values. node_count below 2
// acts as 2, above MAX_NODES (capped at 511) as that cap.
`default_nettype none
module incremental_mst_two_cost_minimizer
	import imstcm_pkg::*;
#(
	parameter int MAX_NODES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [NODE_W-1:0]  from_node,
	input  wire logic [NODE_W-1:0]  to_node,
	input  wire logic [COST_W-1:0]  gold_cost,
	input  wire logic [COST_W-1:0]  silver_cost,
	input  wire logic               last_edge,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [BEST_W-1:0]  best_cost,
	output logic                    found,
	output logic                    spans_now,
	output logic      [KEPT_W-1:0]  kept_edges,
	output logic                    run_done
);

	localparam int NodeCap = (MAX_NODES < 511) ? MAX_NODES : 511;
	localparam int KDepth  = NodeCap;
	localparam int KAW     = $clog2(KDepth);
	localparam int RDepth  = NodeCap + 1;
	localparam int RAW     = $clog2(RDepth);

	state_t state_q, state_d;

	logic [NODE_W-1:0] nc_q;
	logic [COST_W-1:0] gp_q, sp_q;

	logic [NODE_W-1:0] from_q, to_q;
	logic [COST_W-1:0] gold_q, silver_q;
	logic              last_q;

	logic [KAW-1:0]    kept_count_q, j_q, c_q;
	logic              bank_q, ins_done_q, spans_q;
	logic [BEST_W-1:0] best_q;
	logic              have_best_q;
	logic [COST_W-1:0] maxs_q;
	kept_entry_t       e_q;
	logic [RAW-1:0]    cur_q, u_q, w_q;

	kept_entry_t       kmem [0:1][0:KDepth-1];
	kept_entry_t       k_rd;
	logic [RAW-1:0]    rmem [0:RDepth-1];
	logic [RAW-1:0]    r_rd;

	logic [NODE_W-1:0] eff_n, nm1;
	logic              accept, edge_ok, have_old, take_new, e_ok, r_hit;
	logic              scan_end, last_pass, out_load;
	kept_entry_t       e_sel;
	logic [RAW-1:0]    r_raddr;
	logic              r_we, k_we;
	logic              cost_start, cand_valid;
	logic [BEST_W-1:0] cand;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= NODE_W'(2);
			gp_q <= '0;
			sp_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_NODE_COUNT:   nc_q <= pwdata[NODE_W-1:0];
				REG_GOLD_PRICE:   gp_q <= pwdata[COST_W-1:0];
				REG_SILVER_PRICE: sp_q <= pwdata[COST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NODE_COUNT:   prdata = PDATA_W'(nc_q);
			REG_GOLD_PRICE:   prdata = PDATA_W'(gp_q);
			REG_SILVER_PRICE: prdata = PDATA_W'(sp_q);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		if (nc_q < NODE_W'(2)) begin
			eff_n = NODE_W'(2);
		end else if (nc_q > NODE_W'(NodeCap)) begin
			eff_n = NODE_W'(NodeCap);
		end else begin
			eff_n = nc_q;
		end
	end
	assign nm1 = eff_n - NODE_W'(1);

	assign accept  = in_valid && !in_stall;
	assign edge_ok = (from_node != '0) && (from_node <= eff_n) &&
	                 (to_node != '0) && (to_node <= eff_n);

	assign have_old = j_q < kept_count_q;
	assign take_new = !ins_done_q && (!have_old || (k_rd.silver > silver_q));
	always_comb begin
		if (take_new) begin
			e_sel.node_a = from_q;
			e_sel.node_b = to_q;
			e_sel.silver = silver_q;
		end else begin
			e_sel = k_rd;
		end
	end
	assign e_ok = (e_sel.node_a != '0) && (e_sel.node_a <= eff_n) &&
	              (e_sel.node_b != '0) && (e_sel.node_b <= eff_n);
	assign r_hit     = r_rd == cur_q;
	assign scan_end  = (NODE_W'(c_q) == nm1) || (ins_done_q && !have_old);
	assign last_pass = w_q == RAW'(eff_n);
	assign out_load  = !out_valid || !out_stall;

	// next state and memory control
	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		r_raddr    = cur_q;
		r_we       = 1'b0;
		k_we       = 1'b0;
		cost_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = edge_ok ? ST_INIT : ST_FIN;
				end
			end
			ST_INIT: begin
				if (last_pass) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_LD;
			end
			ST_LD: begin
				r_raddr = RAW'(e_sel.node_a);
				state_d = e_ok ? ST_WA : ST_NEXT;
			end
			ST_WA: begin
				if (r_hit) begin
					r_raddr = RAW'(e_q.node_b);
					state_d = ST_WB;
				end else begin
					r_raddr = r_rd;
				end
			end
			ST_WB: begin
				if (r_hit) begin
					r_we    = u_q != cur_q;
					k_we    = u_q != cur_q;
					state_d = ST_NEXT;
				end else begin
					r_raddr = r_rd;
				end
			end
			ST_NEXT: begin
				if (scan_end) begin
					cost_start = NODE_W'(c_q) == nm1;
					state_d    = (NODE_W'(c_q) == nm1) ? ST_COST : ST_FIN;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_COST: begin
				if (cand_valid) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		k_rd <= kmem[bank_q][j_q];
		if (k_we) begin
			kmem[~bank_q][c_q] <= e_q;
		end
	end

	always_ff @(posedge clk) begin
		r_rd <= rmem[r_raddr];
		if (state_q == ST_INIT) begin
			rmem[w_q] <= w_q;
		end else if (r_we) begin
			rmem[u_q] <= cur_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q <= '0;
			bank_q       <= 1'b0;
			best_q       <= '0;
			have_best_q  <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_NEXT: begin
					if (scan_end) begin
						kept_count_q <= c_q;
						bank_q       <= ~bank_q;
					end
				end
				ST_COST: begin
					if (cand_valid && (!have_best_q || (cand < best_q))) begin
						best_q      <= cand;
						have_best_q <= 1'b1;
					end
				end
				ST_FIN: begin
					if (out_load && last_q) begin
						kept_count_q <= '0;
						best_q       <= '0;
						have_best_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					from_q     <= from_node;
					to_q       <= to_node;
					gold_q     <= gold_cost;
					silver_q   <= silver_cost;
					last_q     <= last_edge;
					spans_q    <= 1'b0;
					j_q        <= '0;
					c_q        <= '0;
					ins_done_q <= 1'b0;
					maxs_q     <= '0;
					w_q        <= RAW'(1);
				end
			end
			ST_INIT: begin
				w_q <= w_q + RAW'(1);
			end
			ST_LD: begin
				e_q   <= e_sel;
				cur_q <= RAW'(e_sel.node_a);
				if (take_new) begin
					ins_done_q <= 1'b1;
				end else begin
					j_q <= j_q + KAW'(1);
				end
			end
			ST_WA: begin
				if (r_hit) begin
					u_q   <= cur_q;
					cur_q <= RAW'(e_q.node_b);
				end else begin
					cur_q <= r_rd;
				end
			end
			ST_WB: begin
				if (r_hit) begin
					if (u_q != cur_q) begin
						c_q <= c_q + KAW'(1);
						if (e_q.silver > maxs_q) begin
							maxs_q <= e_q.silver;
						end
					end
				end else begin
					cur_q <= r_rd;
				end
			end
			ST_NEXT: begin
				if (scan_end) begin
					spans_q <= NODE_W'(c_q) == nm1;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					best_cost  <= best_q;
					found      <= have_best_q;
					spans_now  <= spans_q;
					kept_edges <= KEPT_W'(kept_count_q);
					run_done   <= last_q;
				end
			end
			default: ;
		endcase
	end

	imstcm_cost u_cost (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (cost_start),
		.gold         (gold_q),
		.silver_max   (maxs_q),
		.gold_price   (gp_q),
		.silver_price (sp_q),
		.cand_valid   (cand_valid),
		.cand         (cand)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/imstcm_checker.sv =====
// Port-level checker of the spanning-tree cost minimizer and its bind
`default_nettype none
`include "incremental_mst_two_cost_minimizer_defines.svh"
module imstcm_checker
	import imstcm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [BEST_W-1:0] best_cost,
	input wire logic              found,
	input wire logic              spans_now
);

	`IMSTCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`IMSTCM_ASSERT_NEXT(a_best_hold, out_valid && out_stall, $stable(best_cost), "stalled best_cost moved")
	`IMSTCM_ASSERT_SAME(a_empty_best, out_valid && !found, best_cost == '0, "best_cost set without a find")
	`IMSTCM_ASSERT_SAME(a_span_found, out_valid && spans_now, found, "spanning result not recorded")

endmodule

bind incremental_mst_two_cost_minimizer imstcm_checker u_imstcm_checker (.*);
`default_nettype wire

// ===== bench/incremental_mst_two_cost_minimizer_test.sv =====
// Self-checking testbench for the incremental two-cost spanning-tree minimizer
`default_nettype none
module incremental_mst_two_cost_minimizer_test;
	import imstcm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODE_LIMIT = 256;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam logic [63:0] BEST_MASK = 64'h1FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [BEST_W-1:0] best;
		bit                found;
		bit                spans;
		logic [KEPT_W-1:0] kept;
		bit                done;
	} span_result_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0;
	logic               penable = 0;
	logic               pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 0;
	logic               in_stall;
	logic [NODE_W-1:0]  from_node = '0;
	logic [NODE_W-1:0]  to_node = '0;
	logic [COST_W-1:0]  gold_cost = '0;
	logic [COST_W-1:0]  silver_cost = '0;
	logic               last_edge = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [BEST_W-1:0]  best_cost;
	logic               found;
	logic               spans_now;
	logic [KEPT_W-1:0]  kept_edges;
	logic               run_done;

	incremental_mst_two_cost_minimizer #(.MAX_NODES(NODE_LIMIT)) dut (.*);

	always #6 clk = ~clk;

	// shadow of the block's registers and state
	int unsigned  node_reg = 2;
	int unsigned  gold_price_reg = 0;
	int unsigned  silver_price_reg = 0;
	int unsigned  forest_from [NODE_LIMIT];
	int unsigned  forest_to [NODE_LIMIT];
	int unsigned  forest_silver [NODE_LIMIT];
	int unsigned  forest_size = 0;
	int unsigned  root_of [NODE_LIMIT + 1];
	logic [63:0]  cheapest = 0;
	bit           have_cheapest = 0;

	span_result_t pending_results[$];
	int           errors = 0;
	int           edges_sent = 0;
	int           results_seen = 0;
	int           spanning_seen = 0;
	int           reg_writes = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           hold_left = 0;
	int           cycles = 0;

	function automatic int unsigned find_root(int unsigned x);
		int unsigned r;
		r = x;
		while (root_of[r] != r)
			r = root_of[r];
		return r;
	endfunction

	task automatic predict_edge(input int unsigned f, input int unsigned t,
			input logic [63:0] gold, input int unsigned silver, input bit last,
			output span_result_t res);
		int unsigned n, conn, max_silver, u, v, tmp;
		logic [63:0] cand;
		bit spans;
		n = node_reg < 2 ? 2 : (node_reg > NODE_LIMIT ? NODE_LIMIT : node_reg);
		spans = 0;
		if (f >= 1 && f <= n && t >= 1 && t <= n && forest_size < NODE_LIMIT) begin
			forest_from[forest_size] = f;
			forest_to[forest_size] = t;
			forest_silver[forest_size] = silver;
			forest_size++;
			for (int j = forest_size - 1; j >= 1; j--) begin
				if (forest_silver[j] < forest_silver[j-1]) begin
					tmp = forest_from[j]; forest_from[j] = forest_from[j-1]; forest_from[j-1] = tmp;
					tmp = forest_to[j]; forest_to[j] = forest_to[j-1]; forest_to[j-1] = tmp;
					tmp = forest_silver[j];
					forest_silver[j] = forest_silver[j-1];
					forest_silver[j-1] = tmp;
				end
			end
			for (int j = 1; j <= n; j++)
				root_of[j] = j;
			conn = 0;
			max_silver = 0;
			for (int j = 0; j < forest_size; j++) begin
				if (forest_from[j] >= 1 && forest_from[j] <= n &&
						forest_to[j] >= 1 && forest_to[j] <= n) begin
					u = find_root(forest_from[j]);
					v = find_root(forest_to[j]);
					if (u != v) begin
						if (forest_silver[j] > max_silver)
							max_silver = forest_silver[j];
						forest_from[conn] = forest_from[j];
						forest_to[conn] = forest_to[j];
						forest_silver[conn] = forest_silver[j];
						conn++;
						root_of[u] = v;
					end
				end
				if (conn == n - 1)
					break;
			end
			forest_size = conn;
			if (conn == n - 1) begin
				cand = gold * 64'(gold_price_reg) + 64'(max_silver) * 64'(silver_price_reg);
				spans = 1;
				if (!have_cheapest || cand < cheapest) begin
					cheapest = cand & BEST_MASK;
					have_cheapest = 1;
				end
			end
		end
		res.best = have_cheapest ? cheapest[BEST_W-1:0] : '0;
		res.found = have_cheapest;
		res.spans = spans;
		res.kept = forest_size[KEPT_W-1:0];
		res.done = last;
		if (last) begin
			forest_size = 0;
			cheapest = 0;
			have_cheapest = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// drive one edge and hold it until transfer; valid stays high afterwards
	task automatic send_edge(input int unsigned f, input int unsigned t,
			input logic [COST_W-1:0] gold, input logic [COST_W-1:0] silver, input bit last);
		span_result_t res;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1;
		from_node <= f[NODE_W-1:0];
		to_node <= t[NODE_W-1:0];
		gold_cost <= gold;
		silver_cost <= silver;
		last_edge <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_edge(f[NODE_W-1:0], t[NODE_W-1:0], 64'(gold), silver, last, res);
		pending_results.push_back(res);
		edges_sent++;
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_NODE_COUNT:   node_reg = value[NODE_W-1:0];
			REG_GOLD_PRICE:   gold_price_reg = value[COST_W-1:0];
			REG_SILVER_PRICE: silver_price_reg = value[COST_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_regs(input int unsigned n, input int unsigned gp, input int unsigned sp);
		drain();
		write_reg(REG_NODE_COUNT, n);
		write_reg(REG_GOLD_PRICE, gp);
		write_reg(REG_SILVER_PRICE, sp);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk) begin
		span_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("unexpected transfer on output at cycle %0d", cycles);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (want.spans)
					spanning_seen++;
				if (best_cost !== want.best)
					report_mismatch("best_cost", best_cost, want.best);
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (spans_now !== want.spans)
					report_mismatch("spans_now", spans_now, want.spans);
				if (kept_edges !== want.kept)
					report_mismatch("kept_edges", kept_edges, want.kept);
				if (run_done !== want.done)
					report_mismatch("run_done", run_done, want.done);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("incremental_mst_two_cost_minimizer_test NOT OK");
			$finish;
		end
	end

	task automatic test_directed;
		set_regs(4, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
		send_edge(1, 2, 0, 30'h3FFF_FFFF, 0);
		send_edge(3, 3, 1, 5, 0);
		send_edge(0, 1, 2, 5, 0);
		send_edge(5, 1, 2, 5, 0);
		send_edge(511, 256, 2, 5, 0);
		send_edge(2, 3, 3, 7, 0);
		send_edge(3, 4, 4, 9, 0);
		send_edge(1, 4, 2, 1, 0);
		send_edge(4, 2, 30'h3FFF_FFFF, 0, 1);
		set_regs(8, 3, 5);
		for (int i = 1; i < 8; i++)
			send_edge(i, i + 1, i, 100 - i, 0);
		set_regs(4, 3, 5);
		send_edge(1, 3, 10, 1, 0);
		send_edge(2, 4, 11, 2, 1);
		set_regs(0, 1, 1);
		send_edge(2, 1, 0, 0, 1);
		set_regs(1, 0, 0);
		send_edge(1, 2, 0, 0, 1);
		set_regs(511, 2, 3);
		send_edge(256, 1, 5, 30'h2AAA_AAAA, 0);
		send_edge(1, 256, 6, 30'h1555_5555, 1);
		set_regs(256, 1, 1);
		send_edge(257, 2, 7, 1, 1);
	endtask

	task automatic random_run(input int unsigned n, input int unsigned edges);
		logic [COST_W-1:0] gold;
		int unsigned f, t;
		logic [COST_W-1:0] silver;
		gold = $urandom_range(3) == 0 ? COST_W'($urandom) : COST_W'($urandom_range(50));
		for (int i = 0; i < edges; i++) begin
			if ($urandom_range(99) < 85) begin
				f = $urandom_range(1, n);
				t = $urandom_range(1, n);
				gold = gold + COST_W'($urandom_range(20));
			end else begin
				f = $urandom_range(511);
				t = $urandom_range(511);
				gold = COST_W'($urandom);
			end
			silver = $urandom_range(1) ? COST_W'($urandom) : COST_W'($urandom_range(15));
			send_edge(f, t, gold, silver, i == edges - 1);
		end
	endtask

	task automatic test_random(input int unsigned items, input int iq, input int sq);
		int unsigned n, done_items, len;
		idle_pct = iq;
		stall_pct = sq;
		done_items = 0;
		while (done_items < items) begin
			n = $urandom_range(9) == 0 ? $urandom_range(40, 256) : $urandom_range(2, 8);
			len = n > 8 ? 12 : $urandom_range(1, 3 * n);
			set_regs(n, $urandom_range(3) == 0 ? $urandom : $urandom_range(100),
				$urandom_range(3) == 0 ? $urandom : $urandom_range(100));
			random_run(n, len);
			done_items += len;
		end
		drain();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure;
		set_regs(5, 2, 3);
		hold_left = 600;
		random_run(5, 14);
		drain();
		random_run(5, 4);
		drain();
		random_run(5, 6);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(55, 0, 0);
		test_random(55, 77, 0);
		test_random(55, 0, 77);
		test_random(55, 25, 25);
		test_backpressure();
		drain();
		repeat (50) @(posedge clk);
		$display("sent %0d edges, checked %0d results, %0d of them spanning",
			edges_sent, results_seen, spanning_seen);
		$display("%0d register writes across node counts and price settings", reg_writes);
		if (errors == 0 && pending_results.size() == 0)
			$display("incremental_mst_two_cost_minimizer_test OK");
		else
			$display("incremental_mst_two_cost_minimizer_test NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
